### rtl/segenv_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// segment envelope generator package
// shared types, field widths, request and phase codes, register indexes
// ----------------------------------------------------------------------------
package segenv_pkg;

	// field types
	typedef logic [1:0]  mode_t;
	typedef logic [3:0]  seg_idx_t;
	typedef logic [31:0] gain_t;
	typedef logic [23:0] frames_t;
	typedef logic [4:0]  seg_cnt_t;
	typedef logic [23:0] amp_t;
	typedef logic [1:0]  phase_t;

	// one table slot
	typedef struct packed {
		gain_t   gain;
		frames_t len;
	} seg_entry_t;

	// default table depth
	localparam int SEG_MAX_DEF = 16;

	// request codes
	localparam mode_t MODE_LOAD    = 2'd0;
	localparam mode_t MODE_KEY_ON  = 2'd1;
	localparam mode_t MODE_KEY_OFF = 2'd2;
	localparam mode_t MODE_TICK    = 2'd3;

	// envelope phases
	localparam phase_t PH_IDLE     = 2'd0;
	localparam phase_t PH_ACTIVE   = 2'd1;
	localparam phase_t PH_RELEASED = 2'd2;
	localparam phase_t PH_DEAD     = 2'd3;

	// Q1.23 full scale and the release floor after reset (about -72 dB)
	localparam amp_t FULL_SCALE  = 24'd8388608;
	localparam amp_t FLOOR_RESET = 24'd2107;

	// Q2.30 rounding
	localparam int GAIN_FRAC = 30;

	// configuration port
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 24;
	localparam logic [CFG_IDX_W-1:0] REG_IGNORE_RELEASE = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_RELEASE_FLOOR  = 1'd1;

endpackage

### rtl/segenv_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// segment envelope request channel
// valid/ready channel carrying one load, key or tick request
// ----------------------------------------------------------------------------
interface segenv_req_if;
	import segenv_pkg::*;

	logic     valid;
	logic     ready;
	mode_t    mode;
	seg_idx_t seg_index;
	gain_t    seg_multiplier;
	frames_t  seg_frames;
	seg_cnt_t seg_count;

	modport source (
		output valid, mode, seg_index, seg_multiplier, seg_frames, seg_count,
		input  ready
	);

	modport sink (
		input  valid, mode, seg_index, seg_multiplier, seg_frames, seg_count,
		output ready
	);

endinterface

### rtl/segenv_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// segment envelope result channel
// valid/ready channel carrying the envelope state after each request
// ----------------------------------------------------------------------------
interface segenv_rsp_if;
	import segenv_pkg::*;

	logic     valid;
	logic     ready;
	amp_t     amplitude;
	phase_t   phase;
	seg_idx_t current_segment;
	logic     voice_done;

	modport source (
		output valid, amplitude, phase, current_segment, voice_done,
		input  ready
	);

	modport sink (
		input  valid, amplitude, phase, current_segment, voice_done,
		output ready
	);

endinterface

### rtl/segment_envelope_generator.sv
`timescale 1ns / 1ps
// request path: registered in stage s1, then in the output register that drives rsp
// throughput: one request per cycle unless rsp stalls, set by the single table
//   read port (read on accept) followed by one 24x32 multiply in the update stage
// reset: control state, phase, level and registers return to their defaults at once;
//   the segment table is undefined until loaded, no clearing pass
// ----------------------------------------------------------------------------
// segment envelope generator
// multiplicative envelope driven by a table of segments (gain, length)
// ----------------------------------------------------------------------------
module segment_envelope_generator #(
	parameter int MAX_SEGMENTS = segenv_pkg::SEG_MAX_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	segenv_req_if.sink                       req,
	segenv_rsp_if.source                     rsp,
	input  logic                             cfg_we,
	input  logic [segenv_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [segenv_pkg::CFG_DATA_W-1:0] cfg_wdata
);
	import segenv_pkg::*;

	// table address and segment count widths
	localparam int AW = $clog2(MAX_SEGMENTS);
	localparam int CW = $clog2(MAX_SEGMENTS + 1);
	localparam int PW = 56;

	// ------------------------------------------------------------------
	// configuration registers
	// ------------------------------------------------------------------
	logic ign_rel_q;
	amp_t floor_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ign_rel_q <= 1'b0;
			floor_q   <= FLOOR_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_IGNORE_RELEASE: ign_rel_q <= cfg_wdata[0];
				REG_RELEASE_FLOOR:  floor_q   <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// ------------------------------------------------------------------
	// handshake control
	// stage s1 holds an accepted request plus its table read data,
	// the output register holds the finished result
	// ------------------------------------------------------------------
	logic s1_v_q;
	logic s1_adv;
	logic acc;
	logic out_v_q;

	assign s1_adv    = s1_v_q && (!out_v_q || rsp.ready);
	assign req.ready = !s1_v_q || s1_adv;
	assign acc       = req.valid && req.ready;

	// ------------------------------------------------------------------
	// envelope state
	// ------------------------------------------------------------------
	phase_t          phase_q;
	logic [AW-1:0]   now_q;
	logic [CW-1:0]   total_q;
	frames_t         frames_q;
	gain_t           gain_q;
	amp_t            level_q;

	// stage s1 payload
	mode_t           mode_s1;
	logic [CW-1:0]   cnt_s1;
	seg_entry_t      rd_s1;

	// next state from the request in s1 (equals current state when s1 is empty)
	phase_t          phase_d;
	logic [AW-1:0]   now_d;
	logic [CW-1:0]   total_d;
	frames_t         frames_d;
	gain_t           gain_d;
	logic            done_d;
	logic            slope;
	amp_t            level_d;

	logic [CW-1:0]   tot_m1;
	logic [CW:0]     now_ext;
	logic [CW:0]     tot_ext;

	assign tot_m1  = total_q - CW'(1);
	assign now_ext = (CW+1)'(now_q);
	assign tot_ext = (CW+1)'(total_q);

	always_comb begin
		phase_d  = phase_q;
		now_d    = now_q;
		total_d  = total_q;
		frames_d = frames_q;
		gain_d   = gain_q;
		done_d   = 1'b0;
		slope    = 1'b0;
		if (s1_v_q) begin
			case (mode_s1)
				MODE_KEY_ON: begin
					// restart from slot 0 at full scale
					total_d  = cnt_s1;
					phase_d  = PH_ACTIVE;
					now_d    = '0;
					gain_d   = rd_s1.gain;
					frames_d = rd_s1.len;
				end
				MODE_KEY_OFF: begin
					if (phase_q == PH_ACTIVE || phase_q == PH_RELEASED) begin
						phase_d = PH_RELEASED;
						// jump to the last counted segment unless release is ignored or the count is zero
						if (!ign_rel_q && total_q != '0) begin
							now_d    = tot_m1[AW-1:0];
							gain_d   = rd_s1.gain;
							frames_d = rd_s1.len;
						end
					end
				end
				MODE_TICK: begin
					slope = (phase_q != PH_DEAD);
					case (phase_q)
						PH_ACTIVE: begin
							if (frames_q > frames_t'(1)) begin
								frames_d = frames_q - frames_t'(1);
							end else begin
								frames_d = '0;
								// advance while a later non-final segment exists
								if (now_ext + (CW+1)'(2) < tot_ext) begin
									now_d    = now_q + AW'(1);
									gain_d   = rd_s1.gain;
									frames_d = rd_s1.len;
								end
							end
						end
						PH_RELEASED: begin
							// released voice dies on the last segment below the floor
							if (now_ext + (CW+1)'(1) == tot_ext && level_q < floor_q) begin
								phase_d = PH_DEAD;
								done_d  = 1'b1;
							end
						end
						default: ;
					endcase
				end
				default: ;
			endcase
		end
	end

	// level times gain in Q2.30, round half up, clamp to full scale
	logic [PW-1:0]           prod;
	logic [PW-1:0]           prod_rnd;
	logic [PW-GAIN_FRAC-1:0] lvl_wide;

	assign prod     = PW'(level_q) * PW'(gain_d);
	assign prod_rnd = prod + (PW'(1) << (GAIN_FRAC - 1));
	assign lvl_wide = prod_rnd[PW-1:GAIN_FRAC];

	always_comb begin
		level_d = level_q;
		if (s1_v_q && mode_s1 == MODE_KEY_ON) begin
			level_d = FULL_SCALE;
		end else if (slope) begin
			if (lvl_wide > (PW-GAIN_FRAC)'(FULL_SCALE)) begin
				level_d = FULL_SCALE;
			end else begin
				level_d = lvl_wide[23:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_IDLE;
			now_q    <= '0;
			total_q  <= '0;
			frames_q <= '0;
			gain_q   <= '0;
			level_q  <= '0;
		end else if (s1_adv) begin
			phase_q  <= phase_d;
			now_q    <= now_d;
			total_q  <= total_d;
			frames_q <= frames_d;
			gain_q   <= gain_d;
			level_q  <= level_d;
		end
	end

	// ------------------------------------------------------------------
	// segment table, one write or one read per accepted request
	// the read address comes from the state that the request in s1 leaves
	// ------------------------------------------------------------------
	seg_entry_t      seg_mem [MAX_SEGMENTS];
	logic [AW-1:0]   raddr;
	logic [AW-1:0]   waddr;
	logic [CW-1:0]   rd_tot_m1;
	logic            wr_ok;
	logic [CW-1:0]   cnt_sat;

	assign rd_tot_m1 = total_d - CW'(1);
	assign waddr     = AW'(req.seg_index);
	assign wr_ok     = (32'(req.seg_index) < MAX_SEGMENTS);
	assign cnt_sat   = (32'(req.seg_count) > MAX_SEGMENTS) ? CW'(MAX_SEGMENTS)
	                                                       : CW'(req.seg_count);

	always_comb begin
		case (req.mode)
			MODE_KEY_ON:  raddr = '0;
			MODE_KEY_OFF: raddr = rd_tot_m1[AW-1:0];
			default:      raddr = now_d + AW'(1);
		endcase
	end

	always_ff @(posedge clk) begin
		if (acc && req.mode == MODE_LOAD && wr_ok) begin
			seg_mem[waddr] <= '{gain: req.seg_multiplier, len: req.seg_frames};
		end
	end

	always_ff @(posedge clk) begin
		if (acc && req.mode != MODE_LOAD) begin
			rd_s1 <= seg_mem[raddr];
		end
	end

	// s1 payload
	always_ff @(posedge clk) begin
		if (acc) begin
			mode_s1 <= req.mode;
			cnt_s1  <= cnt_sat;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v_q <= 1'b0;
		end else if (acc) begin
			s1_v_q <= 1'b1;
		end else if (s1_adv) begin
			s1_v_q <= 1'b0;
		end
	end

	// ------------------------------------------------------------------
	// output register
	// ------------------------------------------------------------------
	amp_t     amp_q;
	phase_t   ph_out_q;
	seg_idx_t seg_out_q;
	logic     done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (s1_adv) begin
			out_v_q <= 1'b1;
		end else if (rsp.ready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			amp_q     <= level_d;
			ph_out_q  <= phase_d;
			seg_out_q <= seg_idx_t'(now_d);
			done_q    <= done_d;
		end
	end

	assign rsp.valid           = out_v_q;
	assign rsp.amplitude       = amp_q;
	assign rsp.phase           = ph_out_q;
	assign rsp.current_segment = seg_out_q;
	assign rsp.voice_done      = done_q;

	// ------------------------------------------------------------------
	// assertions
	// ------------------------------------------------------------------
	a_done_dead: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.voice_done |-> rsp.phase == PH_DEAD)
		else $error("voice_done without dead phase");

	a_amp_clamp: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> rsp.amplitude <= FULL_SCALE)
		else $error("amplitude above full scale");

	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		s1_v_q && !s1_adv |=> s1_v_q && $stable(mode_s1))
		else $error("stalled request lost from s1");

	a_key_on: assert property (@(posedge clk) disable iff (!arst_n)
		s1_adv && mode_s1 == MODE_KEY_ON |=>
			rsp.valid && rsp.amplitude == FULL_SCALE && rsp.phase == PH_ACTIVE)
		else $error("key on did not restart the envelope");

endmodule

### tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// segment envelope generator testbench
// a short table of directed requests, then randomized voices (table loads,
// key on, ticks, key off, ticks to silence) under several register settings;
// each result is compared field by field against its typed row or a predictor of the envelope
// ----------------------------------------------------------------------------
module tb;
	import segenv_pkg::*;

	localparam int SEG_SLOTS       = SEG_MAX_DEF;
	localparam int DIR_ROWS        = 25;
	localparam int PHASES          = 6;
	localparam int ITEMS_PER_PHASE = 325;
	localparam int HOLD_OFF_CYCLES = 200;
	localparam int SETTLE_CYCLES   = 6;
	localparam int WATCHDOG_LIMIT  = 3000;

	// Q2.30 gains of one and one half
	localparam gain_t UNITY_GAIN = 32'h4000_0000;
	localparam gain_t HALF_GAIN  = 32'h2000_0000;

	typedef struct packed {
		mode_t    mode;
		seg_idx_t idx;
		gain_t    mult;
		frames_t  frames;
		seg_cnt_t count;
	} env_req_t;

	typedef struct packed {
		amp_t     amplitude;
		phase_t   phase;
		seg_idx_t segment;
		logic     done;
	} env_rsp_t;

	// one row of the directed table; has_exp marks a result typed in by hand
	typedef struct packed {
		env_req_t req;
		logic     has_exp;
		env_rsp_t exp;
	} dir_row_t;

	localparam env_rsp_t IDLE_RSP  = '{24'd0, PH_IDLE, 4'd0, 1'b0};
	localparam env_rsp_t START_RSP = '{FULL_SCALE, PH_ACTIVE, 4'd0, 1'b0};
	localparam env_rsp_t DEAD_RSP  = '{24'd0, PH_DEAD, 4'd15, 1'b0};

	// directed requests, run with the register defaults
	localparam dir_row_t DIRECTED [DIR_ROWS] = '{
		// tick and key off while idle leave everything at reset values
		'{'{MODE_TICK,    4'd0,  32'h0000_0000, 24'h00_0000, 5'd0},  1'b1, IDLE_RSP},
		'{'{MODE_KEY_OFF, 4'd15, 32'hFFFF_FFFF, 24'hFF_FFFF, 5'd31}, 1'b1, IDLE_RSP},
		// loads: largest gain and length, zero gain and length, unity, half
		'{'{MODE_LOAD,    4'd0,  32'hFFFF_FFFF, 24'hFF_FFFF, 5'd0},  1'b1, IDLE_RSP},
		'{'{MODE_LOAD,    4'd15, 32'h0000_0000, 24'h00_0000, 5'd31}, 1'b1, IDLE_RSP},
		'{'{MODE_LOAD,    4'd1,  UNITY_GAIN,    24'd1,       5'd0},  1'b1, IDLE_RSP},
		'{'{MODE_LOAD,    4'd2,  HALF_GAIN,     24'd2,       5'd0},  1'b1, IDLE_RSP},
		// count above the table depth saturates to 16
		'{'{MODE_KEY_ON,  4'd0,  32'h0000_0000, 24'h00_0000, 5'd31}, 1'b1, START_RSP},
		// largest gain clamps at full scale
		'{'{MODE_TICK,    4'd0,  32'h0000_0000, 24'h00_0000, 5'd0},  1'b1, START_RSP},
		// key off jumps to slot 15 (zero gain)
		'{'{MODE_KEY_OFF, 4'd0,  32'h0000_0000, 24'h00_0000, 5'd0},  1'b1,
			'{FULL_SCALE, PH_RELEASED, 4'd15, 1'b0}},
		'{'{MODE_TICK,    4'd0,  32'h0000_0000, 24'h00_0000, 5'd0},  1'b1,
			'{24'd0, PH_RELEASED, 4'd15, 1'b0}},
		// level under the floor on the last segment: voice dies
		'{'{MODE_TICK,    4'd0,  32'h0000_0000, 24'h00_0000, 5'd0},  1'b1,
			'{24'd0, PH_DEAD, 4'd15, 1'b1}},
		'{'{MODE_TICK,    4'd0,  32'h0000_0000, 24'h00_0000, 5'd0},  1'b1, DEAD_RSP},
		// key off while dead is ignored
		'{'{MODE_KEY_OFF, 4'd0,  32'h0000_0000, 24'h00_0000, 5'd0},  1'b1, DEAD_RSP},
		'{'{MODE_LOAD,    4'd0,  UNITY_GAIN,    24'd1,       5'd0},  1'b1, DEAD_RSP},
		// key on from dead restarts
		'{'{MODE_KEY_ON,  4'd0,  32'h0000_0000, 24'h00_0000, 5'd3},  1'b1, START_RSP},
		// segment advance, then the last two segments hold
		'{'{MODE_TICK,    4'd0,  32'h0000_0000, 24'h00_0000, 5'd0},  1'b0, '0},
		'{'{MODE_TICK,    4'd0,  32'h0000_0000, 24'h00_0000, 5'd0},  1'b0, '0},
		'{'{MODE_KEY_OFF, 4'd0,  32'h0000_0000, 24'h00_0000, 5'd0},  1'b0, '0},
		'{'{MODE_TICK,    4'd0,  32'h0000_0000, 24'h00_0000, 5'd0},  1'b0, '0},
		// zero count: key off jumps nowhere, voice never dies
		'{'{MODE_KEY_ON,  4'd7,  32'h1234_5678, 24'hAB_CDEF, 5'd0},  1'b0, '0},
		'{'{MODE_KEY_OFF, 4'd0,  32'h0000_0000, 24'h00_0000, 5'd0},  1'b0, '0},
		'{'{MODE_TICK,    4'd0,  32'h0000_0000, 24'h00_0000, 5'd0},  1'b0, '0},
		// key on while released, full count
		'{'{MODE_KEY_ON,  4'd0,  32'h0000_0000, 24'h00_0000, 5'd16}, 1'b0, '0},
		'{'{MODE_KEY_OFF, 4'd0,  32'h0000_0000, 24'h00_0000, 5'd0},  1'b0, '0},
		'{'{MODE_TICK,    4'd0,  32'h0000_0000, 24'h00_0000, 5'd0},  1'b0, '0}
	};

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	segenv_req_if req_ch ();
	segenv_rsp_if rsp_ch ();

	segment_envelope_generator dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req_ch),
		.rsp       (rsp_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	// 4 ns clock
	always #2 clk = ~clk;

	// envelope predictor state, starts at reset values
	gain_t    seg_gain    [SEG_SLOTS];
	frames_t  seg_len     [SEG_SLOTS];
	bit       slot_loaded [SEG_SLOTS];
	seg_cnt_t seg_total     = '0;
	seg_idx_t seg_now       = '0;
	frames_t  frames_left   = '0;
	gain_t    gain_now      = '0;
	amp_t     env_level     = '0;
	phase_t   env_phase     = PH_IDLE;
	logic     ign_release   = 1'b0;
	amp_t     release_floor = FLOOR_RESET;

	// envelope states still owed by the block, oldest first
	env_rsp_t awaited_states [$];
	env_rsp_t want_rsp;

	// bookkeeping
	int  mismatch_count   = 0;
	int  requests_taken   = 0;
	int  results_checked  = 0;
	int  voices_died      = 0;
	int  settings_used    = 0;
	int  phase_items      = 0;
	int  quiet_cycles     = 0;
	int  stall_left       = 0;
	int  hold_left        = 0;
	bit  hold_off_pending = 1'b0;
	bit  req_steady       = 1'b0;
	bit  rsp_steady       = 1'b0;

	// gap length: mostly none, some short, a few long
	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 70)
			return 0;
		else if (roll < 93)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// segment gain: decays, near unity, growth, extremes and anything
	function automatic gain_t random_gain();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 30)
			return gain_t'($urandom_range(32'h0800_0000, 32'h3FFF_FFFF));
		else if (roll < 50)
			return gain_t'($urandom_range(32'h3E00_0000, 32'h4100_0000));
		else if (roll < 65)
			return gain_t'($urandom_range(32'h4000_0000, 32'h7FFF_FFFF));
		else if (roll < 75) begin
			case ($urandom_range(0, 2))
				0: return '0;
				1: return '1;
				default: return UNITY_GAIN;
			endcase
		end
		return gain_t'($urandom);
	endfunction

	// segment length: mostly a few frames
	function automatic frames_t random_frames();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 70)
			return frames_t'($urandom_range(0, 4));
		else if (roll < 90)
			return frames_t'($urandom_range(5, 40));
		return frames_t'($urandom);
	endfunction

	// every field random
	function automatic env_req_t noise_request();
		env_req_t r;
		r.mode   = mode_t'($urandom);
		r.idx    = seg_idx_t'($urandom);
		r.mult   = gain_t'($urandom);
		r.frames = frames_t'($urandom);
		r.count  = seg_cnt_t'($urandom);
		return r;
	endfunction

	function automatic void enter_segment(input seg_idx_t i);
		seg_now     = i;
		gain_now    = seg_gain[i];
		frames_left = seg_len[i];
	endfunction

	// advance the predictor by one request and return the envelope state after it
	function automatic env_rsp_t envelope_step(input env_req_t r);
		env_rsp_t    o;
		logic [63:0] prod;
		bit          slope;
		o.done = 1'b0;
		slope  = 1'b1;
		case (r.mode)
			MODE_LOAD: begin
				seg_gain[r.idx]    = r.mult;
				seg_len[r.idx]     = r.frames;
				slot_loaded[r.idx] = 1'b1;
			end
			MODE_KEY_ON: begin
				seg_total = (int'(r.count) > SEG_SLOTS) ? seg_cnt_t'(SEG_SLOTS) : r.count;
				env_level = FULL_SCALE;
				env_phase = PH_ACTIVE;
				enter_segment('0);
			end
			MODE_KEY_OFF: begin
				if (env_phase == PH_ACTIVE || env_phase == PH_RELEASED) begin
					env_phase = PH_RELEASED;
					if (!ign_release && seg_total != 0)
						enter_segment(seg_idx_t'(seg_total - 1));
				end
			end
			default: begin
				if (env_phase == PH_ACTIVE) begin
					if (frames_left > 1)
						frames_left = frames_left - 1;
					else begin
						frames_left = '0;
						if (int'(seg_now) + 2 < int'(seg_total))
							enter_segment(seg_idx_t'(seg_now + 4'd1));
					end
				end else if (env_phase == PH_RELEASED) begin
					if (int'(seg_now) + 1 == int'(seg_total) && env_level < release_floor) begin
						env_phase = PH_DEAD;
						o.done    = 1'b1;
					end
				end else if (env_phase == PH_DEAD)
					slope = 1'b0;
				if (slope) begin
					prod = 64'(env_level) * 64'(gain_now);
					prod = (prod + (64'd1 << (GAIN_FRAC - 1))) >> GAIN_FRAC;
					if (prod > 64'(FULL_SCALE))
						prod = 64'(FULL_SCALE);
					env_level = amp_t'(prod);
				end
			end
		endcase
		o.amplitude = env_level;
		o.phase     = env_phase;
		o.segment   = seg_now;
		return o;
	endfunction

	// offer one request at the falling edge, hold it until taken
	task automatic send_request(input env_req_t r, input logic has_exp, input env_rsp_t typed_rsp);
		int       gap;
		env_rsp_t predicted;
		gap = req_steady ? 0 : pick_gap();
		repeat (gap) begin
			@(negedge clk);
			req_ch.valid <= 1'b0;
		end
		@(negedge clk);
		req_ch.valid          <= 1'b1;
		req_ch.mode           <= r.mode;
		req_ch.seg_index      <= r.idx;
		req_ch.seg_multiplier <= r.mult;
		req_ch.seg_frames     <= r.frames;
		req_ch.seg_count      <= r.count;
		do
			@(posedge clk);
		while (req_ch.ready !== 1'b1);
		predicted = envelope_step(r);
		if (has_exp)
			predicted = typed_rsp;
		awaited_states = {awaited_states, predicted};
		requests_taken++;
	endtask

	// random request; a request that would read a slot never loaded loads it instead
	task automatic send_random(input env_req_t r);
		seg_idx_t slot;
		logic     needs_load;
		slot       = '0;
		needs_load = 1'b0;
		case (r.mode)
			MODE_KEY_ON:
				needs_load = !slot_loaded[0];
			MODE_KEY_OFF: begin
				if ((env_phase == PH_ACTIVE || env_phase == PH_RELEASED) &&
						!ign_release && seg_total != 0) begin
					slot       = seg_idx_t'(seg_total - 1);
					needs_load = !slot_loaded[slot];
				end
			end
			MODE_TICK: begin
				if (env_phase == PH_ACTIVE && frames_left <= 1 &&
						int'(seg_now) + 2 < int'(seg_total)) begin
					slot       = seg_idx_t'(seg_now + 4'd1);
					needs_load = !slot_loaded[slot];
				end
			end
			default: ;
		endcase
		if (needs_load) begin
			r.mode   = MODE_LOAD;
			r.idx    = slot;
			r.mult   = random_gain();
			r.frames = random_frames();
		end
		// key off in idle or dead does nothing, so it is not counted
		if (!(r.mode == MODE_KEY_OFF && (env_phase == PH_IDLE || env_phase == PH_DEAD)))
			phase_items++;
		send_request(r, 1'b0, '0);
	endtask

	// register write, only while the block is idle
	task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(negedge clk);
		cfg_we    <= 1'b0;
		if (idx == REG_IGNORE_RELEASE)
			ign_release = val[0];
		else
			release_floor = amp_t'(val);
	endtask

	// stop offering, wait for every owed result and let the pipeline settle
	task automatic wait_for_quiet();
		@(negedge clk);
		req_ch.valid <= 1'b0;
		while (awaited_states.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// result side: random stalls, one long hold-off on demand
	initial begin
		rsp_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_left == 0 && hold_off_pending) begin
				hold_left        = HOLD_OFF_CYCLES;
				hold_off_pending = 1'b0;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp_ch.ready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= 1'b1;
				if (!rsp_steady)
					stall_left = pick_gap();
			end
		end
	end

	// result checker: oldest owed state against each accepted result
	always @(posedge clk) begin
		if (arst_n === 1'b1 && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
			if (awaited_states.size() == 0) begin
				$error("result with no request pending: amplitude %0d phase %0d segment %0d",
					rsp_ch.amplitude, rsp_ch.phase, rsp_ch.current_segment);
				mismatch_count++;
			end else begin
				want_rsp = awaited_states.pop_front();
				if (rsp_ch.amplitude !== want_rsp.amplitude) begin
					$error("amplitude: expected %0d, actual %0d",
						want_rsp.amplitude, rsp_ch.amplitude);
					mismatch_count++;
				end
				if (rsp_ch.phase !== want_rsp.phase) begin
					$error("phase: expected %0d, actual %0d", want_rsp.phase, rsp_ch.phase);
					mismatch_count++;
				end
				if (rsp_ch.current_segment !== want_rsp.segment) begin
					$error("current_segment: expected %0d, actual %0d",
						want_rsp.segment, rsp_ch.current_segment);
					mismatch_count++;
				end
				if (rsp_ch.voice_done !== want_rsp.done) begin
					$error("voice_done: expected %0d, actual %0d",
						want_rsp.done, rsp_ch.voice_done);
					mismatch_count++;
				end
				results_checked++;
				if (want_rsp.done)
					voices_died++;
			end
		end
	end

	// watchdog: too long with no request and no result moving
	always @(posedge clk) begin
		if (arst_n !== 1'b1 || (req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
				(rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1))
			quiet_cycles = 0;
		else begin
			quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("Mismatches found");
				$finish;
			end
		end
	end

	// stimulus
	initial begin
		env_req_t r;
		int       count;
		int       n_slots;
		int       n_ticks;
		int       roll;
		logic     ign_set;
		amp_t     floor_set;

		// every input known from the start while reset is held
		arst_n                = 1'b0;
		cfg_we                = 1'b0;
		cfg_index             = '0;
		cfg_wdata             = '0;
		req_ch.valid          = 1'b0;
		req_ch.mode           = MODE_LOAD;
		req_ch.seg_index      = '0;
		req_ch.seg_multiplier = '0;
		req_ch.seg_frames     = '0;
		req_ch.seg_count      = '0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// defaults written explicitly, the directed table relies on them
		write_register(REG_IGNORE_RELEASE, '0);
		write_register(REG_RELEASE_FLOOR, FLOOR_RESET);
		settings_used = 1;

		for (int i = 0; i < DIR_ROWS; i++)
			send_request(DIRECTED[i].req, DIRECTED[i].has_exp, DIRECTED[i].exp);

		// random voices, one register setting per phase
		for (int p = 0; p < PHASES; p++) begin
			// block drained before the registers change
			wait_for_quiet();
			case (p)
				0: begin ign_set = 1'b1; floor_set = FULL_SCALE; end
				1: begin ign_set = 1'b0; floor_set = '0; end
				2: begin ign_set = 1'b0; floor_set = FULL_SCALE; end
				3: begin ign_set = 1'b1; floor_set = amp_t'($urandom_range(0, FULL_SCALE)); end
				4: begin ign_set = 1'b0; floor_set = amp_t'($urandom_range(0, 65535)); end
				default: begin ign_set = 1'b0; floor_set = FLOOR_RESET; end
			endcase
			write_register(REG_IGNORE_RELEASE, CFG_DATA_W'(ign_set));
			write_register(REG_RELEASE_FLOOR, floor_set);
			settings_used++;

			// some phases run without gaps on one or both sides
			req_steady = (p == 0 || p == 3);
			rsp_steady = (p == 0 || p == 4);
			// long receiver hold-off while requests keep coming
			if (p == 1)
				hold_off_pending = 1'b1;

			phase_items = 0;
			while (phase_items < ITEMS_PER_PHASE) begin
				// segment count for this voice, mostly short envelopes
				roll = $urandom_range(0, 99);
				if (roll < 75)
					count = $urandom_range(1, 6);
				else if (roll < 88)
					count = $urandom_range(7, 16);
				else if (roll < 94)
					count = $urandom_range(17, 31);
				else
					count = 0;
				n_slots = (count > SEG_SLOTS) ? SEG_SLOTS : ((count == 0) ? 1 : count);

				// fill the table, sometimes keeping an older slot
				for (int s = 0; s < n_slots; s++) begin
					if (!slot_loaded[s] || $urandom_range(0, 3) != 0) begin
						r        = noise_request();
						r.mode   = MODE_LOAD;
						r.idx    = seg_idx_t'(s);
						r.mult   = random_gain();
						r.frames = random_frames();
						send_random(r);
					end
				end

				r       = noise_request();
				r.mode  = MODE_KEY_ON;
				r.count = seg_cnt_t'(count);
				send_random(r);

				// attack and sustain ticks with a little noise mixed in
				n_ticks = $urandom_range(0, 24);
				repeat (n_ticks) begin
					r = noise_request();
					if ($urandom_range(0, 19) != 0)
						r.mode = MODE_TICK;
					send_random(r);
				end

				// usually a key off, sometimes the next key on cuts in instead
				if ($urandom_range(0, 9) != 0) begin
					r      = noise_request();
					r.mode = MODE_KEY_OFF;
					send_random(r);
				end

				// release ticks until the voice dies or a limit is hit
				n_ticks = $urandom_range(8, 48);
				while (n_ticks > 0 && env_phase != PH_DEAD) begin
					r      = noise_request();
					r.mode = MODE_TICK;
					send_random(r);
					n_ticks--;
				end
				// a few more ticks, usually on a dead voice
				repeat ($urandom_range(0, 2)) begin
					r      = noise_request();
					r.mode = MODE_TICK;
					send_random(r);
				end
			end
		end

		wait_for_quiet();
		$display("run summary: %0d requests, %0d results checked, %0d register settings",
			requests_taken, results_checked, settings_used);
		$display("run summary: %0d voices released to silence, hold-off and drains applied",
			voices_died);
		if (mismatch_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

### filelist.f
rtl/segenv_pkg.sv
rtl/segenv_req_if.sv
rtl/segenv_rsp_if.sv
rtl/segment_envelope_generator.sv
tb/sv/tb.sv
